/* hw/rtl/dpfa_pkg.sv */
package dpfa_pkg;

    localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
    localparam logic [5:0]  LZC_EMPTY    = 6'h3f;

    // stage 1 -> stage 2: aligned operands
    typedef struct packed {
        logic [63:0] nrm;
        logic [63:0] sh;
        logic        subtract;
        logic        sign;
        logic [10:0] pre;
        logic        inf;
    } align_t;

    // stage 2 -> stage 3: raw sum with leading-zero count
    typedef struct packed {
        logic [63:0] sum;
        logic [5:0]  lz;
        logic        sign;
        logic [10:0] pre;
        logic        inf;
    } add_t;

    // Leading zeros of bits 60..0 of a 61-bit word; LZC_EMPTY when all zero.
    function automatic logic [5:0] lzc61(input logic [60:0] x);
        logic [5:0] n;
        logic       found;
        n = LZC_EMPTY;
        found = 1'b0;
        for (int i = 60; i >= 0; i--) begin
            if (!found && x[i]) begin
                n = 6'(60 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

/* hw/rtl/double_precision_float_adder_unit.sv */
// Double-precision adder, truncating, no rounding.
// Input stream s_axis_*: tdata = {operand_b, operand_a}, operand_a in bits 63:0.
// Output stream m_axis_*: tdata = sum_bits.
// A transaction is taken whenever tvalid and tready are both high.
// Pipeline: input register, align register, add/count register, output
// register; m_axis_tvalid rises once a pair has reached the output register.
// Throughput is one pair per cycle while the receiver does not stall;
// each stage has a valid bit.
// When the receiver stalls, a stage advances only into an empty slot or one
// that empties in the same cycle, so nothing is dropped or repeated and
// s_axis_tready falls once the pipe is full.
// Reset (rst_n low, asynchronous) clears all valid bits; data regs are not reset.
module double_precision_float_adder_unit
    import dpfa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] operand_a, [127:64] operand_b
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata    // [63:0] sum_bits
);

    logic [127:0] in_reg;
    align_t       al_reg, al_next;
    add_t         ad_reg, ad_next;
    logic [63:0]  out_reg, out_next;
    logic [3:0]   v_reg;
    logic [3:0]   adv;

    // stage k advances when its successor is empty or moving
    always_comb
    begin
        adv[3] = !v_reg[3] || m_axis_tready;
        adv[2] = !v_reg[2] || adv[3];
        adv[1] = !v_reg[1] || adv[2];
        adv[0] = !v_reg[0] || adv[1];
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = v_reg[3];
    assign m_axis_tdata  = out_reg;

    dpfa_align u_align (.operand_a(in_reg[63:0]), .operand_b(in_reg[127:64]), .align(al_next));
    dpfa_add   u_add   (.align(al_reg), .add(ad_next));
    dpfa_norm  u_norm  (.add(ad_reg), .sum_bits(out_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 4'd0;
        else
        begin
            if (adv[0]) v_reg[0] <= s_axis_tvalid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
            if (adv[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && s_axis_tvalid) in_reg <= s_axis_tdata;
        if (adv[1] && v_reg[0]) al_reg <= al_next;
        if (adv[2] && v_reg[1]) ad_reg <= ad_next;
        if (adv[3] && v_reg[2]) out_reg <= out_next;
    end

endmodule

/* hw/rtl/dpfa_align.sv */
module dpfa_align
    import dpfa_pkg::*;
(
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    output align_t      align
);

    logic [10:0] ea, eb, big_e, small_e, diff;
    logic [51:0] ma, mb, big_m, small_m;
    logic        b_larger;
    logic [63:0] mov;

    always_comb
    begin
        ea = operand_a[62:52];
        eb = operand_b[62:52];
        ma = operand_a[51:0];
        mb = operand_b[51:0];
        b_larger = (ea < eb) || (ea == eb && ma < mb);
        diff = (ea < eb) ? (eb - ea) : (ea - eb);
        big_m = b_larger ? mb : ma;
        small_m = b_larger ? ma : mb;
        big_e = b_larger ? eb : ea;
        small_e = b_larger ? ea : eb;
        align.pre = (ea < eb) ? eb : ea;
        align.sign = b_larger ? operand_b[63] : operand_a[63];
        align.subtract = operand_a[63] ^ operand_b[63];
        align.inf = (ea == EXP_ALL_ONES) || (eb == EXP_ALL_ONES);
        align.nrm = {2'b00, (big_e != 11'd0), big_m, 9'd0};
        mov = {2'b00, (small_e != 11'd0), small_m, 9'd0};
        align.sh = (diff >= 11'd64) ? 64'd0 : (mov >> diff[5:0]);
    end

endmodule

/* hw/rtl/dpfa_add.sv */
module dpfa_add
    import dpfa_pkg::*;
(
    input  align_t align,
    output add_t   add
);

    always_comb
    begin
        add.sum = align.subtract ? (align.nrm - align.sh) : (align.nrm + align.sh);
        add.lz = lzc61(add.sum[61:1]);
        add.sign = align.sign;
        add.pre = align.pre;
        add.inf = align.inf;
    end

endmodule

/* hw/rtl/dpfa_norm.sv */
module dpfa_norm
    import dpfa_pkg::*;
(
    input  add_t        add,
    output logic [63:0] sum_bits
);

    logic [60:0] norm;
    logic [51:0] mant;
    logic [12:0] expo;

    always_comb
    begin
        norm = add.sum[61:1] << add.lz;
        if (add.sum[62])
        begin
            mant = add.sum[61:10];
            expo = {2'b00, add.pre} + 13'd1;
        end
        else if (add.sum[61])
        begin
            mant = add.sum[60:9];
            expo = {2'b00, add.pre};
        end
        else
        begin
            mant = norm[59:8];
            expo = {2'b00, add.pre} - {7'd0, add.lz};
        end
        if (expo[12] || expo == 13'd0 || (add.lz == LZC_EMPTY && !add.sum[62]))
            sum_bits = 64'd0;
        else if (add.inf || expo[11])
            sum_bits = {add.sign, EXP_ALL_ONES, 52'd0};
        else
            sum_bits = {add.sign, expo[10:0], mant};
    end

endmodule

/* hw/rtl/dpfa_checker.sv */
module dpfa_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata
);

    // hold output while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // a free output side never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked with receiver ready");

    // an input transaction taken while the receiver stays ready raises m_axis_tvalid
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tready && $past(m_axis_tready)
        && $past(m_axis_tready, 2) && $past(m_axis_tready, 3)
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing after pipeline latency");

    // a valid result carries known data
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !$isunknown(m_axis_tdata))
        else $error("unknown data on valid output");

endmodule

bind double_precision_float_adder_unit dpfa_checker u_dpfa_checker (.*);

/* dv/tb_double_precision_float_adder_unit.sv */
module tb_double_precision_float_adder_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import dpfa_pkg::*;

    // Pipeline latency from input transaction to the earliest output transaction.
    localparam int PIPE_LATENCY = 4;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // [63:0] operand_a, [127:64] operand_b
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;   // [63:0] sum_bits

    // Sums still owed by the pipe, oldest first.
    logic [63:0] pending_sums[$];
    int          mismatch_count;
    bit          stall_enable;

    double_precision_float_adder_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Give a gap length: mostly zero or short, sometimes long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        else if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Compute the truncated double sum the way the hardware does.
    function automatic logic [63:0] truncated_sum(input logic [63:0] a, input logic [63:0] b);
        logic [10:0] exp_a;
        logic [10:0] exp_b;
        logic [51:0] frac_a;
        logic [51:0] frac_b;
        logic        b_wins;
        logic        any_inf;
        logic        diff_signs;
        logic        big_sign;
        logic [10:0] diff;
        logic [10:0] top_exp;
        logic [63:0] big_word;
        logic [63:0] small_word;
        logic [63:0] aligned;
        logic [63:0] raw;
        logic [60:0] field;
        logic [60:0] shifted;
        logic [5:0]  zeros;
        logic [51:0] frac_out;
        logic [12:0] exp_out;
        exp_a = a[62:52];
        exp_b = b[62:52];
        frac_a = a[51:0];
        frac_b = b[51:0];
        any_inf = (exp_a == EXP_ALL_ONES) || (exp_b == EXP_ALL_ONES);
        b_wins = (exp_a < exp_b) || (exp_a == exp_b && frac_a < frac_b);
        diff = (exp_a < exp_b) ? exp_b - exp_a : exp_a - exp_b;
        top_exp = (exp_a < exp_b) ? exp_b : exp_a;
        big_sign = b_wins ? b[63] : a[63];
        diff_signs = a[63] ^ b[63];
        // Hidden bit at 61, stored fraction at 60..9, guard bits below.
        big_word = {2'b00, ((b_wins ? exp_b : exp_a) != 0), (b_wins ? frac_b : frac_a), 9'd0};
        small_word = {2'b00, ((b_wins ? exp_a : exp_b) != 0), (b_wins ? frac_a : frac_b), 9'd0};
        aligned = (diff >= 64) ? 64'd0 : small_word >> diff;
        raw = diff_signs ? big_word + ~aligned + 64'd1 : big_word + aligned;
        field = raw[61:1];
        zeros = LZC_EMPTY;
        for (int i = 0; i <= 60; i++)
        begin
            if (field[i])
            begin
                zeros = 6'(60 - i);
            end
        end
        shifted = (zeros == LZC_EMPTY) ? 61'd0 : field << zeros;
        if (raw[62])
        begin
            frac_out = raw[61:10];
            exp_out = 13'(top_exp) + 13'd1;
        end
        else if (raw[61])
        begin
            frac_out = raw[60:9];
            exp_out = 13'(top_exp);
        end
        else
        begin
            frac_out = shifted[59:8];
            exp_out = 13'(top_exp) - 13'(zeros);
        end
        // Underflow and exact zero win over infinity.
        if (exp_out[12] || exp_out == 13'd0 || (zeros == LZC_EMPTY && !raw[62]))
        begin
            return 64'd0;
        end
        if (any_inf || exp_out[11])
        begin
            return {big_sign, EXP_ALL_ONES, 52'd0};
        end
        return {big_sign, exp_out[10:0], frac_out};
    endfunction

    // Offer one operand pair after a random gap and hold it until taken.
    // tvalid stays up afterwards so a pair with no gap follows back to back.
    task automatic send_pair(input logic [63:0] a, input logic [63:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        pending_sums.push_back(truncated_sum(a, b));
        @(negedge clk);
    endtask

    // Drop tvalid after the last pair of a burst.
    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [63:0] make_double(input bit sgn, input logic [10:0] e,
                                                input logic [51:0] f);
        return {sgn, e, f};
    endfunction

    // Exponent spread toward zero, all ones, nearby values and values around the bias.
    function automatic logic [10:0] pick_exp();
        case ($urandom_range(0, 5))
            0: return 11'd0;
            1: return EXP_ALL_ONES;
            2: return 11'($urandom_range(1, 4));
            3: return 11'($urandom_range(2040, 2046));
            default: return 11'($urandom_range(960, 1090));
        endcase
    endfunction

    task automatic test_special_values();
        logic [63:0] one;
        one = make_double(1'b0, 11'd1023, 52'd0);
        send_pair(64'd0, 64'd0);
        send_pair(one, one);
        send_pair(one, {1'b1, one[62:0]});
        send_pair(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        send_pair(make_double(1'b0, EXP_ALL_ONES, 52'd0), one);
        send_pair(make_double(1'b1, EXP_ALL_ONES, 52'h1), one);
        send_pair(make_double(1'b0, EXP_ALL_ONES, 52'd0),
                  make_double(1'b1, EXP_ALL_ONES, 52'd0));
        send_pair(make_double(1'b0, 11'h7fe, '1), make_double(1'b0, 11'h7fe, '1));
        send_pair(make_double(1'b0, 11'd0, 52'h1), make_double(1'b0, 11'd0, 52'h3));
        send_pair(make_double(1'b0, 11'd0, '1), make_double(1'b1, 11'd1, 52'd0));
        send_pair(make_double(1'b0, 11'd1, 52'd0), make_double(1'b1, 11'd1, 52'h1));
        send_pair(make_double(1'b0, 11'd2000, 52'h5), make_double(1'b1, 11'd1, '1));
        send_pair(make_double(1'b1, 11'd1023, 52'h8_0000_0000_0000), one);
        send_pair(make_double(1'b0, 11'd1100, '1), make_double(1'b0, 11'd1040, '1));
        send_pair(make_double(1'b0, 11'd1100, 52'd0), make_double(1'b1, 11'd1099, '1));
        send_pair(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    endtask

    // Hold off the next operands until every owed sum has come back.
    task automatic test_drain_pause();
        send_pair(make_double(1'b0, 11'd1030, 52'h1234), make_double(1'b1, 11'd1029, 52'h9876));
        end_burst();
        while (pending_sums.size() != 0)
        begin
            @(negedge clk);
        end
        send_pair(make_double(1'b1, 11'd5, 52'hf), make_double(1'b1, 11'd5, 52'hf));
    endtask

    task automatic test_random_pairs(input int count);
        logic [63:0] a;
        logic [63:0] b;
        for (int n = 0; n < count; n++)
        begin
            a = {$urandom, $urandom};
            b = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0:
                begin
                    a[62:52] = pick_exp();
                    b[62:52] = pick_exp();
                end
                1:
                begin
                    // Near cancellation: same or adjacent exponent.
                    b[62:52] = a[62:52] + 11'($urandom_range(0, 1));
                    if ($urandom_range(0, 1))
                    begin
                        b[51:20] = a[51:20];
                    end
                end
                2: b[62:52] = a[62:52] - 11'($urandom_range(50, 70));
                default: ;
            endcase
            send_pair(a, b);
        end
    endtask

    // Check each returned sum against the oldest prediction.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_sums.size() == 0)
                begin
                    $display("%0t: unexpected sum, expected none, actual %h", $time,
                             m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    if (m_axis_tdata !== pending_sums[0])
                    begin
                        $display("%0t: sum_bits expected %h actual %h", $time,
                                 pending_sums[0], m_axis_tdata);
                        mismatch_count++;
                    end
                    void'(pending_sums.pop_front());
                end
            end
        end
    end

    // Receiver back-pressure: random stalls once stall_enable is set, with quiet stretches.
    initial
    begin
        int gap;
        m_axis_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (stall_enable && $urandom_range(0, 3) == 0)
            begin
                gap = pick_gap() + 1;
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Timeout guard.
    initial
    begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        mismatch_count = 0;
        stall_enable = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_special_values();
        test_drain_pause();
        test_random_pairs(150);
        stall_enable = 1'b1;
        test_random_pairs(880);
        end_burst();
        wait_cycles = 0;
        while (pending_sums.size() != 0 && wait_cycles < 10000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (PIPE_LATENCY * 4) @(negedge clk);
        if (mismatch_count == 0 && pending_sums.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
